// ===== rtl/fat_directory_name_match_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the FAT directory name matcher
// Property forms used by the fdnm_core module of the block.
// ----------------------------------------------------------------------------
`ifndef FAT_DIRECTORY_NAME_MATCH_TOP_ASSERT_SVH
`define FAT_DIRECTORY_NAME_MATCH_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FDNM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FDNM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fdnm_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT directory name matcher package
// Item types, command and status codes, entry constants and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fdnm_pkg;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  name_char;
      logic [63:0] entry_word0;
      logic [63:0] entry_word1;
      logic [63:0] entry_word2;
      logic [63:0] entry_word3;
      logic [14:0] entry_position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] match_position;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PIECE,
      ST_SUM,
      ST_CMP,
      ST_DONE
   } state_type;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_ENTRY  = 2'd2;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_MATCH   = 2'd1;
   localparam logic [1:0] STATUS_END     = 2'd2;
   localparam logic [1:0] STATUS_BADNAME = 2'd3;

   localparam logic [7:0]  BYTE_END      = 8'h00;
   localparam logic [7:0]  BYTE_DELETED  = 8'he5;
   localparam logic [7:0]  ATTR_LFN      = 8'h0f;
   localparam int          ATTR_VOL_BIT  = 3;
   localparam int          LFN_LAST_BIT  = 6;
   localparam logic [7:0]  CHAR_SPACE    = 8'h20;
   localparam logic [7:0]  CHAR_DOT      = 8'h2e;
   localparam logic [15:0] CHAR_LOW      = 16'h0021;
   localparam logic [15:0] CHAR_HIGH     = 16'h007e;
   localparam logic [15:0] CHAR_PAD      = 16'hffff;

   localparam int LFN_CHARS      = 13;
   localparam int CHECKSUM_BYTES = 11;
   localparam int LEN_W          = 9;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h61:8'h7a]}) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // Byte offset of each UTF-16 character slot within a long-name piece.
   function automatic logic [4:0] lfn_char_offset(input logic [3:0] k);
      logic [4:0] r;
      case (k)
         4'd0:    r = 5'd1;
         4'd1:    r = 5'd3;
         4'd2:    r = 5'd5;
         4'd3:    r = 5'd7;
         4'd4:    r = 5'd9;
         4'd5:    r = 5'd14;
         4'd6:    r = 5'd16;
         4'd7:    r = 5'd18;
         4'd8:    r = 5'd20;
         4'd9:    r = 5'd22;
         4'd10:   r = 5'd24;
         4'd11:   r = 5'd28;
         4'd12:   r = 5'd30;
         default: r = 5'd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fdnm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fdnm_core.sv =====
// ----------------------------------------------------------------------------
// FAT directory name matcher core
// Sequencer with one byte-wide compare unit, the search name and long-name
// stores, and the long-name tracking state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_directory_name_match_top_assert.svh"

module fdnm_core #(
   parameter int LONG_NAME_CAP = 256,
   parameter int SEARCH_MAX    = 255,
   parameter int MAX_ORDINAL   = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fdnm_pkg::req_type in_item,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output fdnm_pkg::rsp_type      res_item
);

   localparam int SLEN_W = $clog2(SEARCH_MAX + 1);
   localparam int SA_W   = (SEARCH_MAX > 1) ? $clog2(SEARCH_MAX) : 1;
   localparam int LA_W   = $clog2(LONG_NAME_CAP);
   localparam int CNT_W  = (SLEN_W > 4) ? SLEN_W : 4;
   localparam int LW     = fdnm_pkg::LEN_W;

   fdnm_pkg::state_type state_ff, state_in;

   logic [255:0]             ent_ff, ent_in;
   logic [14:0]              epos_ff, epos_in;
   fdnm_pkg::rsp_type        res_ff, res_in;
   logic [SLEN_W-1:0]        slen_ff, slen_in;
   logic                     search_ovf_ff, search_ovf_in;
   logic [LW-1:0]            ln_len_ff, ln_len_in;
   logic [4:0]               next_ord_ff, next_ord_in;
   logic [7:0]               lfn_sum_ff, lfn_sum_in;
   logic                     lfn_active_ff, lfn_active_in;
   logic                     len_known_ff, len_known_in;
   logic                     lfn_invalid_ff, lfn_invalid_in;
   logic [LONG_NAME_CAP-1:0] ln_valid_ff, ln_valid_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [LW-1:0]            piece_pos_ff, piece_pos_in;
   logic [7:0]               sum_ff, sum_in;
   logic                     long_ok_ff, long_ok_in;
   logic                     short_ok_ff, short_ok_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]         cmp_idx_ff, cmp_idx_in;

   logic [7:0]   eb [32];
   logic         accept;
   logic [7:0]   first_byte;
   logic [7:0]   attr_byte;
   logic [4:0]   ord;
   logic         last_piece;
   logic         bad_search;
   logic         is_end;
   logic         is_del;
   logic         is_lfn;
   logic         bad_start;
   logic         eff_active;
   logic [4:0]   eff_next;
   logic [7:0]   eff_sum;
   logic         hdr_fail;
   logic         dec_piece;
   logic         dec_short;
   logic [4:0]   char_off;
   logic [15:0]  piece_char;
   logic [7:0]   sum_next;
   logic         sum_last;
   logic         long_go;
   logic         short_go;
   logic         cmp_end;
   logic         fin;
   logic         do_clear;
   logic [3:0]   base_len;
   logic [1:0]   ext_len;
   logic [3:0]   short_len;
   logic [3:0]   vis_idx;
   logic [7:0]   vis_char;
   logic [LW-1:0] cmp_idx9;
   logic [LW-1:0] rd_idx9;
   logic         cmp_lvalid;
   logic         s_wr;
   logic         l_wr;
   logic [7:0]   s_rd;
   logic [7:0]   l_rd;

   fdnm_ram #(.WIDTH(8), .DEPTH(SEARCH_MAX)) u_search_ram (
      .clock   (clock),
      .wr_en   (s_wr),
      .wr_addr (slen_ff[SA_W-1:0]),
      .wr_data (in_item.name_char),
      .rd_addr (cnt_ff[SA_W-1:0]),
      .rd_data (s_rd)
   );

   fdnm_ram #(.WIDTH(8), .DEPTH(LONG_NAME_CAP)) u_long_ram (
      .clock   (clock),
      .wr_en   (l_wr),
      .wr_addr (piece_pos_ff[LA_W-1:0]),
      .wr_data (piece_char[7:0]),
      .rd_addr (rd_idx9[LA_W-1:0]),
      .rd_data (l_rd)
   );

   always_comb begin
      for (int i = 0; i < 32; i++) begin
         eb[i] = ent_ff[i*8 +: 8];
      end
   end

   // Entry decode.
   assign accept     = in_valid && (state_ff == fdnm_pkg::ST_IDLE);
   assign first_byte = eb[0];
   assign attr_byte  = eb[11];
   assign ord        = first_byte[4:0];
   assign last_piece = first_byte[fdnm_pkg::LFN_LAST_BIT];
   assign bad_search = (slen_ff == '0) || search_ovf_ff;
   assign is_end     = first_byte == fdnm_pkg::BYTE_END;
   assign is_del     = first_byte == fdnm_pkg::BYTE_DELETED;
   assign is_lfn     = attr_byte == fdnm_pkg::ATTR_LFN;
   assign bad_start  = last_piece && ((ord == 5'd0) || (ord > 5'(MAX_ORDINAL)));
   assign eff_active = last_piece || lfn_active_ff;
   assign eff_next   = last_piece ? ord : next_ord_ff;
   assign eff_sum    = last_piece ? eb[13] : lfn_sum_ff;
   assign hdr_fail   = !eff_active || (ord == 5'd0) || (ord != eff_next) ||
                       (eb[12] != 8'h00) || ({eb[27], eb[26]} != 16'h0000) ||
                       (eb[13] != eff_sum);
   assign dec_piece  = !bad_search && !is_end && !is_del && is_lfn &&
                       !bad_start && !hdr_fail;
   assign dec_short  = !bad_search && !is_end && !is_del && !is_lfn;

   // One long-name character per cycle.
   assign char_off   = fdnm_pkg::lfn_char_offset(cnt_ff[3:0]);
   assign piece_char = {eb[char_off + 5'd1], eb[char_off]};

   // Short-name checksum, one byte per cycle.
   assign sum_next = {sum_ff[0], sum_ff[7:1]} + eb[5'(cnt_ff[3:0])];
   assign sum_last = cnt_ff == CNT_W'(fdnm_pkg::CHECKSUM_BYTES - 1);

   // Visible 8.3 name: trailing spaces of both parts dropped.
   always_comb begin
      base_len = 4'd0;
      ext_len  = 2'd0;
      for (int j = 0; j < 8; j++) begin
         if (eb[j] != fdnm_pkg::CHAR_SPACE) begin
            base_len = 4'(j + 1);
         end
      end
      for (int j = 0; j < 3; j++) begin
         if (eb[8 + j] != fdnm_pkg::CHAR_SPACE) begin
            ext_len = 2'(j + 1);
         end
      end
   end

   assign short_len = base_len + ((ext_len != 2'd0) ? (4'(ext_len) + 4'd1) : 4'd0);
   assign vis_idx   = cmp_idx_ff[3:0];

   always_comb begin
      if (vis_idx < base_len) begin
         vis_char = eb[5'(vis_idx)];
      end else if (vis_idx == base_len) begin
         vis_char = fdnm_pkg::CHAR_DOT;
      end else begin
         vis_char = eb[5'(vis_idx) + 5'd7 - 5'(base_len)];
      end
   end

   assign long_go  = !attr_byte[fdnm_pkg::ATTR_VOL_BIT] && lfn_active_ff && !lfn_invalid_ff &&
                     (next_ord_ff == 5'd0) && (lfn_sum_ff == sum_next) &&
                     (ln_len_ff == LW'(slen_ff));
   assign short_go = !attr_byte[fdnm_pkg::ATTR_VOL_BIT] && (LW'(short_len) == LW'(slen_ff));

   assign cmp_idx9   = LW'(cmp_idx_ff);
   assign rd_idx9    = LW'(cnt_ff);
   assign cmp_lvalid = (cmp_idx9 < LW'(LONG_NAME_CAP)) && ln_valid_ff[cmp_idx9[LA_W-1:0]];
   assign cmp_end    = (cnt_ff == CNT_W'(slen_ff)) && !cmp_vld_ff;

   assign fin = ((state_ff == fdnm_pkg::ST_SUM) && sum_last && !long_go && !short_go) ||
                ((state_ff == fdnm_pkg::ST_CMP) && cmp_end);

   assign do_clear = ((state_ff == fdnm_pkg::ST_DECODE) && !bad_search &&
                      (is_end || is_del || (is_lfn && last_piece))) || fin;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdnm_pkg::ST_IDLE: begin
            if (accept && (in_item.cmd == fdnm_pkg::CMD_ENTRY)) begin
               state_in = fdnm_pkg::ST_DECODE;
            end
         end
         fdnm_pkg::ST_DECODE: begin
            if (dec_piece) begin
               state_in = fdnm_pkg::ST_PIECE;
            end else if (dec_short) begin
               state_in = fdnm_pkg::ST_SUM;
            end else begin
               state_in = fdnm_pkg::ST_DONE;
            end
         end
         fdnm_pkg::ST_PIECE: begin
            if (cnt_ff == CNT_W'(fdnm_pkg::LFN_CHARS - 1)) begin
               state_in = fdnm_pkg::ST_DONE;
            end
         end
         fdnm_pkg::ST_SUM: begin
            if (sum_last) begin
               state_in = (long_go || short_go) ? fdnm_pkg::ST_CMP : fdnm_pkg::ST_DONE;
            end
         end
         fdnm_pkg::ST_CMP: begin
            if (cmp_end) begin
               state_in = fdnm_pkg::ST_DONE;
            end
         end
         fdnm_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = fdnm_pkg::ST_IDLE;
            end
         end
         default: state_in = fdnm_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      in_ready  = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         fdnm_pkg::ST_IDLE: in_ready  = 1'b1;
         fdnm_pkg::ST_DONE: res_valid = 1'b1;
         default: begin
            in_ready  = 1'b0;
            res_valid = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      ent_in        = ent_ff;
      epos_in       = epos_ff;
      res_in        = res_ff;
      slen_in       = slen_ff;
      search_ovf_in = search_ovf_ff;
      cnt_in        = cnt_ff;
      piece_pos_in  = piece_pos_ff;
      sum_in        = sum_ff;
      long_ok_in    = long_ok_ff;
      short_ok_in   = short_ok_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      s_wr          = 1'b0;
      l_wr          = 1'b0;
      if (do_clear) begin
         ln_len_in      = '0;
         next_ord_in    = 5'd0;
         lfn_sum_in     = 8'h00;
         lfn_active_in  = 1'b0;
         len_known_in   = 1'b0;
         lfn_invalid_in = 1'b0;
         ln_valid_in    = '0;
      end else begin
         ln_len_in      = ln_len_ff;
         next_ord_in    = next_ord_ff;
         lfn_sum_in     = lfn_sum_ff;
         lfn_active_in  = lfn_active_ff;
         len_known_in   = len_known_ff;
         lfn_invalid_in = lfn_invalid_ff;
         ln_valid_in    = ln_valid_ff;
      end

      case (state_ff)
         fdnm_pkg::ST_IDLE: begin
            if (accept) begin
               case (in_item.cmd)
                  fdnm_pkg::CMD_CLEAR: begin
                     slen_in       = '0;
                     search_ovf_in = 1'b0;
                  end
                  fdnm_pkg::CMD_APPEND: begin
                     if (slen_ff < SLEN_W'(SEARCH_MAX)) begin
                        s_wr    = 1'b1;
                        slen_in = slen_ff + 1'b1;
                     end else begin
                        search_ovf_in = 1'b1;
                     end
                  end
                  fdnm_pkg::CMD_ENTRY: begin
                     ent_in  = {in_item.entry_word3, in_item.entry_word2,
                                in_item.entry_word1, in_item.entry_word0};
                     epos_in = in_item.entry_position;
                  end
                  default: begin
                     slen_in = slen_ff;
                  end
               endcase
            end
         end
         fdnm_pkg::ST_DECODE: begin
            cnt_in                = '0;
            sum_in                = 8'h00;
            res_in.match_position = 15'd0;
            res_in.status         = fdnm_pkg::STATUS_NONE;
            if (bad_search) begin
               res_in.status = fdnm_pkg::STATUS_BADNAME;
            end else if (is_end) begin
               res_in.status = fdnm_pkg::STATUS_END;
            end else if (is_lfn && !is_del && !bad_start) begin
               if (hdr_fail) begin
                  lfn_invalid_in = 1'b1;
                  lfn_active_in  = 1'b0;
               end else begin
                  lfn_active_in = 1'b1;
                  next_ord_in   = eff_next;
                  lfn_sum_in    = eff_sum;
                  piece_pos_in  = LW'(ord) * LW'(fdnm_pkg::LFN_CHARS) -
                                  LW'(fdnm_pkg::LFN_CHARS);
               end
            end
         end
         fdnm_pkg::ST_PIECE: begin
            cnt_in       = cnt_ff + 1'b1;
            piece_pos_in = piece_pos_ff + 1'b1;
            if (piece_char == 16'h0000) begin
               // The first terminator inside the first 256 positions fixes the length.
               if (!len_known_ff && !piece_pos_ff[LW-1]) begin
                  ln_len_in    = piece_pos_ff;
                  len_known_in = 1'b1;
               end
            end else if (piece_char != fdnm_pkg::CHAR_PAD) begin
               if ((piece_pos_ff >= LW'(LONG_NAME_CAP)) || (piece_char < fdnm_pkg::CHAR_LOW) ||
                   (piece_char > fdnm_pkg::CHAR_HIGH) ||
                   (len_known_ff && (piece_pos_ff >= ln_len_ff))) begin
                  lfn_invalid_in = 1'b1;
               end else begin
                  l_wr = 1'b1;
                  ln_valid_in[piece_pos_ff[LA_W-1:0]] = 1'b1;
                  if (!len_known_ff && ((piece_pos_ff + 1'b1) > ln_len_ff)) begin
                     ln_len_in = piece_pos_ff + 1'b1;
                  end
               end
            end
            if (cnt_ff == CNT_W'(fdnm_pkg::LFN_CHARS - 1)) begin
               next_ord_in = next_ord_ff - 5'd1;
            end
         end
         fdnm_pkg::ST_SUM: begin
            sum_in     = sum_next;
            cnt_in     = cnt_ff + 1'b1;
            cmp_vld_in = 1'b0;
            if (sum_last) begin
               cnt_in      = '0;
               long_ok_in  = long_go;
               short_ok_in = short_go;
            end
         end
         fdnm_pkg::ST_CMP: begin
            // The address goes out from cnt_ff; the registered read data is compared in the next cycle.
            if (cnt_ff < CNT_W'(slen_ff)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff) begin
               long_ok_in  = long_ok_ff && cmp_lvalid &&
                             (fdnm_pkg::fold_case(l_rd) == fdnm_pkg::fold_case(s_rd));
               short_ok_in = short_ok_ff &&
                             (fdnm_pkg::fold_case(vis_char) == fdnm_pkg::fold_case(s_rd));
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase

      if (fin) begin
         if ((state_ff == fdnm_pkg::ST_CMP) && (long_ok_ff || short_ok_ff)) begin
            res_in.status         = fdnm_pkg::STATUS_MATCH;
            res_in.match_position = epos_ff;
         end else begin
            res_in.status         = fdnm_pkg::STATUS_NONE;
            res_in.match_position = 15'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fdnm_pkg::ST_IDLE;
         slen_ff        <= '0;
         search_ovf_ff  <= 1'b0;
         ln_len_ff      <= '0;
         next_ord_ff    <= 5'd0;
         lfn_sum_ff     <= 8'h00;
         lfn_active_ff  <= 1'b0;
         len_known_ff   <= 1'b0;
         lfn_invalid_ff <= 1'b0;
         ln_valid_ff    <= '0;
         cmp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slen_ff        <= slen_in;
         search_ovf_ff  <= search_ovf_in;
         ln_len_ff      <= ln_len_in;
         next_ord_ff    <= next_ord_in;
         lfn_sum_ff     <= lfn_sum_in;
         lfn_active_ff  <= lfn_active_in;
         len_known_ff   <= len_known_in;
         lfn_invalid_ff <= lfn_invalid_in;
         ln_valid_ff    <= ln_valid_in;
         cmp_vld_ff     <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      epos_ff      <= epos_in;
      res_ff       <= res_in;
      cnt_ff       <= cnt_in;
      piece_pos_ff <= piece_pos_in;
      sum_ff       <= sum_in;
      long_ok_ff   <= long_ok_in;
      short_ok_ff  <= short_ok_in;
      cmp_idx_ff   <= cmp_idx_in;
   end

   assign res_item = res_ff;

   `FDNM_ASSERT_IMP(a_ovf_only_when_full, search_ovf_ff, slen_ff == SLEN_W'(SEARCH_MAX), "search overflow without a full search name")
   `FDNM_ASSERT_IMP(a_piece_needs_active, state_ff == fdnm_pkg::ST_PIECE, lfn_active_ff && (next_ord_ff != 5'd0), "long-name characters taken without an active name")
   `FDNM_ASSERT_IMP(a_known_len_narrow, len_known_ff, !ln_len_ff[LW-1], "terminated long name longer than 255")
   `FDNM_ASSERT_NXT(a_idle_holds, (state_ff == fdnm_pkg::ST_IDLE) && !(in_valid && (in_item.cmd == fdnm_pkg::CMD_ENTRY)), state_ff == fdnm_pkg::ST_IDLE, "sequencer left idle without an entry item")

endmodule

`default_nettype wire

// ===== rtl/fat_directory_name_match_top.sv =====
// ----------------------------------------------------------------------------
// FAT directory name matcher, top level
// Items enter on the req_ channel: cmd 0 clears the search name, cmd 1
// appends one character, cmd 2 presents a 32-byte directory entry. Only an
// entry item gives a result item on the rsp_ channel (status and position).
// Clear and append items give no result. An entry item goes from the decode
// state straight to the done state when the search name is bad, the entry
// is an end marker or deleted, or a long-name piece fails its start or
// header checks. A good long-name piece passes through the piece state; a
// short entry runs a checksum pass over its 11 name bytes and then, if it
// can still match, the compare state, where one byte-wide compare unit walks
// the search name a character per cycle. The block takes one item at a time
// and holds req_stall high while it works. A finished result waits in an
// output register, so the next item is taken while rsp_stall holds that
// result.
// Reset clears the search name length, the long-name state and both
// channels; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_name_match_top #(
   parameter int LONG_NAME_CAP = 256,
   parameter int SEARCH_MAX    = 255,
   parameter int MAX_ORDINAL   = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire fdnm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fdnm_pkg::rsp_type      rsp_data
);

   logic              core_ready;
   logic              core_res_valid;
   logic              core_res_ready;
   fdnm_pkg::rsp_type core_res;
   logic              rsp_valid_ff, rsp_valid_in;
   fdnm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   fdnm_core #(
      .LONG_NAME_CAP (LONG_NAME_CAP),
      .SEARCH_MAX    (SEARCH_MAX),
      .MAX_ORDINAL   (MAX_ORDINAL)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (core_ready),
      .in_item   (req_data),
      .res_valid (core_res_valid),
      .res_ready (core_res_ready),
      .res_item  (core_res)
   );

   assign req_stall      = !core_ready;
   assign core_res_ready = !rsp_valid_ff || !rsp_stall;

   // The output register refills in the cycle its item leaves.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (core_res_valid && core_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/fat_directory_name_match_top_tb.sv =====
// ----------------------------------------------------------------------------
// FAT directory name matcher testbench
// Drives search-name loads, long-name piece chains, short entries and noise
// into the block, predicts every status item and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_name_match_top_tb;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int ITEM_GOAL   = 1250;

   // Command code the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Predicts the status item of each directory entry and checks results.
   class fat_name_scoreboard;
      fdnm_pkg::rsp_type status_q[$];
      int          errors;
      int          entries_seen;
      int          matches_seen;
      int          pieces_seen;
      byte unsigned lfn_chars[512];
      int unsigned long_len;
      int unsigned next_ord;
      int unsigned piece_sum;
      bit          long_active;
      bit          long_len_known;
      bit          long_bad;
      byte unsigned search_chars[256];
      int unsigned search_len;
      bit          search_full;

      function new();
         clear_lfn();
         search_len  = 0;
         search_full = 0;
      endfunction

      function void clear_lfn();
         foreach (lfn_chars[i]) lfn_chars[i] = 8'hff;
         long_len       = 0;
         next_ord       = 0;
         piece_sum      = 0;
         long_active    = 0;
         long_len_known = 0;
         long_bad       = 0;
      endfunction

      static function byte unsigned upcase(byte unsigned c);
         return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
      endfunction

      static function logic [7:0] short_checksum(logic [255:0] e);
         logic [7:0] s;
         s = 0;
         for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + e[i*8 +: 8];
         return s;
      endfunction

      function void take_piece(logic [255:0] e);
         int unsigned offs[13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
         int unsigned ord, pos, v;
         ord = 32'(e[4:0]);
         if (e[6]) begin
            clear_lfn();
            if (ord == 0 || ord > 20) return;
            long_active = 1;
            next_ord    = ord;
            piece_sum   = 32'(e[13*8 +: 8]);
         end
         if (!long_active || ord == 0 || ord != next_ord || e[12*8 +: 8] != 0 ||
             e[26*8 +: 16] != 0 || e[13*8 +: 8] != piece_sum) begin
            long_bad    = 1;
            long_active = 0;
            return;
         end
         for (int k = 0; k < 13; k++) begin
            pos = (ord - 1) * 13 + k;
            v   = 32'(e[offs[k]*8 +: 16]);
            if (v == 0) begin
               if (!long_len_known && pos <= 255) begin
                  long_len       = pos;
                  long_len_known = 1;
               end
            end else if (v != 16'hffff) begin
               if (pos >= 256 || v < 16'h21 || v > 16'h7e ||
                   (long_len_known && pos >= long_len)) begin
                  long_bad = 1;
               end else begin
                  lfn_chars[pos] = v[7:0];
                  if (!long_len_known && pos + 1 > long_len) long_len = pos + 1;
               end
            end
         end
         next_ord = (next_ord - 1) & 5'h1f;
      endfunction

      function bit long_hit(logic [255:0] e);
         if (!long_active || long_bad || next_ord != 0 || piece_sum != short_checksum(e))
            return 0;
         for (int unsigned i = 0; i < long_len; i++)
            if (i >= 256 || lfn_chars[i] == 8'hff) return 0;
         if (long_len != search_len) return 0;
         for (int unsigned i = 0; i < search_len; i++)
            if (upcase(lfn_chars[i]) != upcase(search_chars[i])) return 0;
         return 1;
      endfunction

      function bit short_hit(logic [255:0] e);
         byte unsigned vis[$];
         int base, ext;
         base = 8;
         ext  = 3;
         while (base != 0 && e[(base-1)*8 +: 8] == fdnm_pkg::CHAR_SPACE) base--;
         while (ext != 0 && e[(7+ext)*8 +: 8] == fdnm_pkg::CHAR_SPACE) ext--;
         for (int i = 0; i < base; i++) vis.push_back(e[i*8 +: 8]);
         if (ext != 0) begin
            vis.push_back(fdnm_pkg::CHAR_DOT);
            for (int i = 0; i < ext; i++) vis.push_back(e[(8+i)*8 +: 8]);
         end
         if (vis.size() != search_len) return 0;
         foreach (vis[i])
            if (upcase(vis[i]) != upcase(search_chars[i])) return 0;
         return 1;
      endfunction

      function void note_item(fdnm_pkg::req_type r);
         logic [255:0]      e;
         fdnm_pkg::rsp_type x;
         bit                hit;
         e = {r.entry_word3, r.entry_word2, r.entry_word1, r.entry_word0};
         x = '0;
         case (r.cmd)
            fdnm_pkg::CMD_CLEAR: begin
               search_len  = 0;
               search_full = 0;
               return;
            end
            fdnm_pkg::CMD_APPEND: begin
               if (search_len < 255) begin
                  search_chars[search_len] = r.name_char;
                  search_len++;
               end else begin
                  search_full = 1;
               end
               return;
            end
            fdnm_pkg::CMD_ENTRY: ;
            default: return;
         endcase
         entries_seen++;
         if (search_len == 0 || search_full) begin
            x.status = fdnm_pkg::STATUS_BADNAME;
         end else if (e[7:0] == fdnm_pkg::BYTE_END) begin
            clear_lfn();
            x.status = fdnm_pkg::STATUS_END;
         end else if (e[7:0] == fdnm_pkg::BYTE_DELETED) begin
            clear_lfn();
         end else if (e[11*8 +: 8] == fdnm_pkg::ATTR_LFN) begin
            pieces_seen++;
            take_piece(e);
         end else begin
            hit = !e[11*8 + fdnm_pkg::ATTR_VOL_BIT] && (long_hit(e) || short_hit(e));
            clear_lfn();
            if (hit) begin
               x.status         = fdnm_pkg::STATUS_MATCH;
               x.match_position = r.entry_position;
               matches_seen++;
            end
         end
         status_q.push_back(x);
      endfunction

      function void check_result(fdnm_pkg::rsp_type got);
         fdnm_pkg::rsp_type want;
         if (status_q.size() == 0) begin
            $error("result item with nothing expected: status %0d position %0d",
                   got.status, got.match_position);
            errors++;
            return;
         end
         want = status_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.match_position !== want.match_position) begin
            $error("match_position: expected %0d, actual %0d",
                   want.match_position, got.match_position);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   fdnm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   fdnm_pkg::rsp_type rsp_data;

   fat_directory_name_match_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   fat_name_scoreboard sb = new();
   int  cycles;
   int  taken;
   int  items_sent;
   int  idle_pct;
   int  stall_pct;
   bit  holding;

   initial clock = 0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         sb.note_item(req_data);
         taken <= taken + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(negedge clock) begin
      rsp_stall <= holding ? 1'b1 : ($urandom_range(99) < stall_pct);
   end

   function automatic logic [255:0] random_bits();
      logic [255:0] e;
      for (int i = 0; i < 8; i++) e[i*32 +: 32] = $urandom;
      return e;
   endfunction

   task automatic send(logic [1:0] cmd, logic [7:0] ch, logic [255:0] e);
      fdnm_pkg::req_type r;
      int                n;
      r.cmd            = cmd;
      r.name_char      = ch;
      {r.entry_word3, r.entry_word2, r.entry_word1, r.entry_word0} = e;
      r.entry_position = 15'($urandom_range(32767));
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data  = r;
      n         = taken;
      do @(negedge clock); while (taken == n);
      items_sent++;
   endtask

   task automatic send_entry(logic [255:0] e);
      send(fdnm_pkg::CMD_ENTRY, 8'($urandom), e);
   endtask

   // Loads a search name, flipping the case of letters at random.
   task automatic load_search(byte unsigned nm[$]);
      byte unsigned c;
      send(fdnm_pkg::CMD_CLEAR, 8'($urandom), random_bits());
      foreach (nm[i]) begin
         c = nm[i];
         if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a) && $urandom_range(1))
            c ^= 8'h20;
         send(fdnm_pkg::CMD_APPEND, c, random_bits());
      end
   endtask

   // A plausible 8.3 entry; its visible name comes back in vis.
   function automatic logic [255:0] random_short(output byte unsigned vis[$]);
      logic [255:0] e;
      int           base, ext;
      logic [7:0]   attr;
      e    = random_bits();
      base = $urandom_range(1, 8);
      ext  = $urandom_range(0, 3);
      vis  = {};
      for (int i = 0; i < 8; i++) begin
         e[i*8 +: 8] = (i < base) ? 8'(8'h41 + $urandom_range(25)) : fdnm_pkg::CHAR_SPACE;
         if (i < base) vis.push_back(e[i*8 +: 8]);
      end
      if (ext != 0) vis.push_back(fdnm_pkg::CHAR_DOT);
      for (int i = 0; i < 3; i++) begin
         e[(8+i)*8 +: 8] = (i < ext) ? 8'(8'h30 + $urandom_range(9)) : fdnm_pkg::CHAR_SPACE;
         if (i < ext) vis.push_back(e[(8+i)*8 +: 8]);
      end
      attr = 8'($urandom);
      if ($urandom_range(9) != 0) attr[fdnm_pkg::ATTR_VOL_BIT] = 0;
      if (attr == fdnm_pkg::ATTR_LFN) attr = 8'h20;
      e[11*8 +: 8] = attr;
      return e;
   endfunction

   // A long-name piece chain followed by its short entry.
   task automatic lfn_chain_group();
      byte unsigned nm[$];
      byte unsigned vis[$];
      logic [255:0] se, pc;
      logic [7:0]   sum;
      logic [15:0]  v;
      int           len, pieces, pos;
      bit           corrupt;
      len = ($urandom_range(19) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 30);
      for (int i = 0; i < len; i++) nm.push_back(8'($urandom_range(8'h21, 8'h7e)));
      if (len <= 255 && $urandom_range(3) != 0) load_search(nm);
      se      = random_short(vis);
      sum     = fat_name_scoreboard::short_checksum(se);
      pieces  = (len + 12) / 13;
      corrupt = ($urandom_range(7) == 0);
      for (int o = pieces; o >= 1; o--) begin
         pc          = random_bits();
         pc[7:0]     = 8'(o) | ((o == pieces) ? 8'h40 : 8'h00);
         pc[95:88]   = fdnm_pkg::ATTR_LFN;
         pc[103:96]  = 8'h00;
         pc[111:104] = sum;
         pc[223:208] = 16'h0000;
         for (int k = 0; k < fdnm_pkg::LFN_CHARS; k++) begin
            pos = (o - 1) * 13 + k;
            v   = (pos < len) ? 16'(nm[pos]) : (pos == len) ? 16'h0000 : fdnm_pkg::CHAR_PAD;
            pc[fdnm_pkg::lfn_char_offset(4'(k))*8 +: 16] = v;
         end
         if (corrupt && $urandom_range(pieces - 1) == 0) pc[$urandom_range(255)] ^= 1'b1;
         send_entry(pc);
      end
      send_entry(se);
   endtask

   task automatic random_group();
      byte unsigned nm[$];
      logic [255:0] e;
      int           pick, len;
      pick = $urandom_range(99);
      if (pick < 10) begin
         len = ($urandom_range(29) == 0) ? $urandom_range(200, 258) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++)
            nm.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                         8'(8'h41 + $urandom_range(25)));
         load_search(nm);
      end else if (pick < 55) begin
         lfn_chain_group();
      end else if (pick < 80) begin
         e = random_short(nm);
         if ($urandom_range(1)) load_search(nm);
         send_entry(e);
      end else begin
         e = random_bits();
         case ($urandom_range(5))
            0: send_entry(e);
            1: begin e[7:0] = fdnm_pkg::BYTE_END; send_entry(e); end
            2: begin e[7:0] = fdnm_pkg::BYTE_DELETED; send_entry(e); end
            3: send(CMD_UNUSED, 8'($urandom), e);
            4: send(fdnm_pkg::CMD_APPEND, 8'($urandom), e);
            default: begin e[95:88] = fdnm_pkg::ATTR_LFN; send_entry(e); end
         endcase
      end
   endtask

   task automatic long_hold();
      holding = 1;
      repeat (800) @(negedge clock);
      holding = 0;
   endtask

   initial begin
      byte unsigned nm[$];
      logic [255:0] e;
      int           goal;
      int           per_phase;
      reset      = 1;
      req_valid  = 0;
      req_data   = '0;
      rsp_stall  = 0;
      holding    = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      cycles     = 0;
      taken      = 0;
      items_sent = 0;
      repeat (5) @(negedge clock);
      reset = 0;

      // Directed: empty name, extreme bytes, markers, bad long-name starts,
      // a volume label, the unknown command and a search name that overflows.
      send(fdnm_pkg::CMD_CLEAR, 8'hff, '1);
      send_entry(random_bits());
      send(fdnm_pkg::CMD_APPEND, 8'h00, '0);
      send(fdnm_pkg::CMD_APPEND, 8'hff, '1);
      send(fdnm_pkg::CMD_CLEAR, 8'h00, '0);
      send(fdnm_pkg::CMD_APPEND, "a", '0);
      send_entry('0);
      e = '1; e[7:0] = fdnm_pkg::BYTE_DELETED; send_entry(e);
      e = random_bits(); e[7:0] = 8'h40; e[95:88] = fdnm_pkg::ATTR_LFN; send_entry(e);
      e = random_bits(); e[7:0] = 8'h55; e[95:88] = fdnm_pkg::ATTR_LFN; send_entry(e);
      e = random_bits(); e[7:0] = 8'h01; e[95:88] = fdnm_pkg::ATTR_LFN; send_entry(e);
      e = {{20{8'h00}}, 8'h08, {10{fdnm_pkg::CHAR_SPACE}}, "A"}; send_entry(e);
      e = {{20{8'hff}}, 8'h20, {10{fdnm_pkg::CHAR_SPACE}}, "A"}; send_entry(e);
      send(CMD_UNUSED, 8'hff, '1);
      send(fdnm_pkg::CMD_CLEAR, 8'h00, '0);
      for (int i = 0; i < 256; i++) nm.push_back("x");
      load_search(nm);
      send_entry({{20{8'h00}}, 8'h20, {10{fdnm_pkg::CHAR_SPACE}}, "X"});

      per_phase = (ITEM_GOAL - items_sent) / 4;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 32) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 66 : 32) : 0;
         if (ph == 0) fork long_hold(); join_none
         goal = items_sent + per_phase;
         while (items_sent < goal) random_group();
      end
      req_valid = 0;
      while (sb.status_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);

      $display("Covered %0d entries (%0d long-name pieces), %0d matches, %0d items sent.",
               sb.entries_seen, sb.pieces_seen, sb.matches_seen, items_sent);
      if (sb.errors == 0 && sb.status_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/fdnm_pkg.sv
rtl/fdnm_ram.sv
rtl/fdnm_core.sv
rtl/fat_directory_name_match_top.sv
verif/fat_directory_name_match_top_tb.sv
